// ===== rtl/stereo_phaser_allpass_cascade_defines.svh =====
// Assertion macros for the phaser block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef STEREO_PHASER_ALLPASS_CASCADE_DEFINES_SVH
`define STEREO_PHASER_ALLPASS_CASCADE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/phs_pkg.sv =====
// Shared types, constants and helper functions for the phaser block.
// No dependencies; imported by the interfaces, the tables and the top level.
`timescale 1ns / 1ps
`default_nettype none

package phs_pkg;

    localparam int STAGES_DEF     = 4;
    localparam int CHANNELS_DEF   = 2;
    localparam int TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W   = 24;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int TAB_DATA_W = 33;
    localparam int TAB_ADDR_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd5;

    localparam logic signed [15:0] RST_MIN_LOG  = -16'sd18242;
    localparam logic signed [15:0] RST_MAX_LOG  = -16'sd7342;
    localparam logic [30:0]        RST_LFO_STEP = 31'd44739;
    localparam logic [14:0]        RST_FB_GAIN  = 15'd0;
    localparam logic [15:0]        RST_DEPTH    = 16'd16384;
    localparam logic [1:0]         RST_CHANNELS = 2'd2;

    localparam logic signed [17:0] LOG_CAP   = -18'sd2108;
    localparam logic [14:0]        FB_MAX    = 15'd31785;
    localparam logic [15:0]        DEPTH_MAX = 16'd32768;

    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
    localparam longint unsigned QUARTER_PI_Q30 = 64'd843314857;
    localparam longint unsigned LN2_Q30        = 64'd744261118;
    localparam longint unsigned ONE_Q30        = 64'd1073741824;

    typedef enum logic [1:0] {
        TAB_SIN,
        TAB_EXP,
        TAB_TAN
    } t_tab_sel;

    typedef struct packed {
        t_tab_sel                sel;
        logic [TAB_ADDR_W-1:0]   addr;
    } t_tab_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SIN_RD0,
        S_SIN_RD1,
        S_SIN_MUL,
        S_SIN_FIN,
        S_LOG_MUL,
        S_LOG_FIN,
        S_EXP_RD0,
        S_EXP_RD1,
        S_EXP_MUL,
        S_EXP_FIN,
        S_TAN_RD0,
        S_TAN_RD1,
        S_TAN_MUL,
        S_TAN_FIN,
        S_FB_MUL,
        S_FB_FIN,
        S_AP_MUL_X,
        S_AP_Y,
        S_AP_MUL_Y,
        S_AP_Z,
        S_MIX_MUL_D,
        S_MIX_MUL_W,
        S_MIX_FIN,
        S_DONE
    } t_state;

    // Round to nearest (halves up) and drop 15 fraction bits.
    function automatic logic signed [37:0] rnd15(input logic signed [52:0] v);
        logic signed [52:0] t;
        t = v + 53'sd16384;
        return t[52:15];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        if (v > 53'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -53'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
        if (v > 38'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -38'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Table construction, evaluated at elaboration only.
    function automatic longint sin_small(input longint unsigned m);
        longint unsigned term;
        longint          sum;
        term = m;
        sum  = longint'(m);
        for (int n = 1; n <= 7; n++) begin
            term = (((term * m) >> 30) * m) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic longint cos_small(input longint unsigned m);
        longint unsigned term;
        longint          sum;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int n = 1; n <= 7; n++) begin
            term = (((term * m) >> 30) * m) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic longint sin_turn(input longint unsigned t);
        longint unsigned q;
        longint unsigned w;
        longint unsigned m;
        longint          sa;
        longint          ca;
        q = (t >> 30) & 64'd3;
        w = t & 64'h3FFFFFFF;
        if (w <= 64'd536870912) begin
            m  = (w * HALF_PI_Q30) >> 30;
            sa = sin_small(m);
            ca = cos_small(m);
        end else begin
            m  = ((ONE_Q30 - w) * HALF_PI_Q30) >> 30;
            sa = cos_small(m);
            ca = sin_small(m);
        end
        case (q)
            64'd0:   return sa;
            64'd1:   return ca;
            64'd2:   return -sa;
            default: return -ca;
        endcase
    endfunction

    function automatic longint sine_entry(input int k, input int tb);
        longint unsigned t;
        longint          s;
        t = (64'(k) << (32 - tb)) & 64'hFFFFFFFF;
        s = sin_turn(t) + 64'sd16384;
        return 64'sd32768 + (s >>> 15);
    endfunction

    function automatic longint exp_entry(input int k, input int tb);
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        y    = (64'(k) * LN2_Q30) >> tb;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return longint'(sum);
    endfunction

    function automatic longint tan_entry(input int k, input int tb);
        longint          j;
        longint unsigned m;
        longint unsigned tv;
        j  = 2 * longint'(k) - (longint'(1) << tb);
        m  = (64'(j < 0 ? -j : j) * QUARTER_PI_Q30) >> tb;
        tv = (64'(sin_small(m)) << 30) / 64'(cos_small(m));
        return (j < 0) ? -longint'(tv) : longint'(tv);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/phs_in_if.sv =====
// Input frame channel: valid/ready handshake with a stereo dry sample pair.
// Depends on phs_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface phs_in_if;
    import phs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/phs_out_if.sv =====
// Output frame channel: valid/ready handshake with a stereo mixed sample pair.
// Depends on phs_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface phs_out_if;
    import phs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/phs_tables.sv =====
// Sine, exp2 and tan lookup ROMs (Q2.30 / Q0.16), one registered read a cycle.
// Depends on phs_pkg for entry functions and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module phs_tables
    import phs_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire t_tab_req                     i_req,
    output logic signed [TAB_DATA_W-1:0]      o_data
);
    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int TAW   = TABLE_BITS + 1;

    logic signed [TAB_DATA_W-1:0] w_sin [TSIZE+1];
    logic signed [TAB_DATA_W-1:0] w_exp [TSIZE+1];
    logic signed [TAB_DATA_W-1:0] w_tan [TSIZE+1];
    logic signed [TAB_DATA_W-1:0] r_data;

    for (genvar k = 0; k <= TSIZE; k++) begin : g_rom
        assign w_sin[k] = TAB_DATA_W'(sine_entry(k, TABLE_BITS));
        assign w_exp[k] = TAB_DATA_W'(exp_entry(k, TABLE_BITS));
        assign w_tan[k] = TAB_DATA_W'(tan_entry(k, TABLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        case (i_req.sel)
            TAB_SIN: r_data <= w_sin[i_req.addr[TAW-1:0]];
            TAB_EXP: r_data <= w_exp[i_req.addr[TAW-1:0]];
            TAB_TAN: r_data <= w_tan[i_req.addr[TAW-1:0]];
            default: r_data <= '0;
        endcase
    end

    assign o_data = r_data;
endmodule

`default_nettype wire

// ===== rtl/stereo_phaser_allpass_cascade.sv =====
// Stereo phaser top level: LFO, coefficient lookup and allpass cascade
// on one shared multiplier. Depends on phs_pkg, phs_in_if, phs_out_if, phs_tables.
//
//  Channel   Dir  Payload                      Transaction
//  i_in      in   left_in, right_in (Q1.23)    one dry stereo frame
//  o_out     out  left_out, right_out (Q1.23)  one mixed stereo frame
//  i_cfg_*   in   index 0..5, data 31 bit      one register write
//
// From acceptance to a valid result, a frame runs the sine, log, exp2 and tan
// steps once, then feedback, every allpass stage and the mix for each active
// channel. The single 34x18 multiplier serialises this work: every product passes through it.
// Reset is synchronous, active low, and clears LFO phase and filter state.
// A finished frame waits in the output register; the next frame is taken
// only once that result has been handed off.
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_phaser_allpass_cascade_defines.svh"

module stereo_phaser_allpass_cascade
    import phs_pkg::*;
#(
    parameter int STAGES     = STAGES_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    phs_in_if.sink                     i_in,
    phs_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int NAP   = CHANNELS * STAGES;
    localparam int AW    = (NAP > 1) ? $clog2(NAP) : 1;

    // Configuration registers
    logic signed [15:0] r_min;
    logic signed [15:0] r_max;
    logic [30:0]        r_step;
    logic [14:0]        r_fb;
    logic [15:0]        r_depth;
    logic [1:0]         r_chan_cfg;

    // Sequencer and datapath registers
    t_state                     r_state, n_state;
    logic [31:0]                r_phase;
    logic [31:0]                r_cur_ph;
    logic signed [SAMPLE_W-1:0] r_dry [2];
    logic signed [SAMPLE_W-1:0] r_out [2];
    logic                       r_ovalid;
    logic signed [32:0]         r_ta;
    logic [16:0]                r_u;
    logic [14:0]                r_off;
    logic [31:0]                r_pt;
    logic signed [15:0]         r_a;
    logic signed [31:0]         r_x;
    logic signed [31:0]         r_y;
    logic signed [51:0]         r_prod;
    logic signed [51:0]         r_acc;
    logic [1:0]                 r_ch;
    logic [1:0]                 r_nch;
    logic [SW-1:0]              r_stage;
    logic signed [31:0]         r_ap  [NAP];
    logic signed [31:0]         r_fbm [CHANNELS];

    // Shared multiplier operands and table port
    logic signed [33:0]         w_ma;
    logic signed [17:0]         w_mb;
    t_tab_req                   w_req;
    logic signed [32:0]         w_tab;
    logic                       w_in_ready;

    logic                       w_acc_in;
    logic                       w_acc_out;

    assign w_acc_in  = i_in.valid && w_in_ready;
    assign w_acc_out = r_ovalid && o_out.ready;

    phs_tables #(
        .TABLE_BITS (TABLE_BITS)
    ) u_tables (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_data (w_tab)
    );

    // ---------------------------------------------------------------------
    // Derived values
    // ---------------------------------------------------------------------
    logic [TABLE_BITS-1:0]  w_si;
    logic [15:0]            w_sf;
    logic signed [51:0]     w_p16;
    logic signed [35:0]     w_lerp;
    logic [16:0]            w_u;
    logic signed [15:0]     w_hi;
    logic signed [16:0]     w_diff;
    logic signed [17:0]     w_l;
    logic signed [17:0]     w_lcap;
    logic signed [17:0]     w_offs;
    logic [15:0]            w_r16;
    logic [TABLE_BITS-1:0]  w_ei;
    logic [15:0]            w_ef;
    logic [31:0]            w_mant;
    logic [4:0]             w_sh;
    logic [TAB_ADDR_W-1:0]  w_ti;
    logic signed [35:0]     w_av;
    logic signed [20:0]     w_a21;
    logic signed [15:0]     w_a;
    logic [14:0]            w_fb_eff;
    logic [15:0]            w_depth;
    logic [1:0]             w_nch;
    logic signed [SAMPLE_W-1:0] w_dry;
    logic [AW-1:0]          w_ap_idx;
    logic signed [37:0]     w_r15;
    logic signed [37:0]     w_mix;

    assign w_si   = r_cur_ph[31 -: TABLE_BITS];
    assign w_sf   = r_cur_ph[31-TABLE_BITS -: 16];
    assign w_p16  = r_prod + 52'sd32768;
    assign w_lerp = 36'(r_ta) + w_p16[51:16];

    always_comb begin
        if (w_lerp < 36'sd0) begin
            w_u = '0;
        end else if (w_lerp > 36'sd65536) begin
            w_u = 17'd65536;
        end else begin
            w_u = w_lerp[16:0];
        end
    end

    // Inverted range collapses to the minimum
    assign w_hi   = (r_max < r_min) ? r_min : r_max;
    assign w_diff = 17'(w_hi) - 17'(r_min);
    assign w_l    = 18'(r_min) + $signed({1'b0, r_prod[32:16]});
    assign w_lcap = (w_l > LOG_CAP) ? LOG_CAP : w_l;
    assign w_offs = w_lcap + 18'sd32768;

    assign w_r16  = {r_off[10:0], 5'b0};
    assign w_ei   = w_r16[15 -: TABLE_BITS];
    assign w_ef   = 16'(w_r16 << TABLE_BITS);
    assign w_mant = (w_lerp < 36'sd0) ? 32'd0 : w_lerp[31:0];
    // Combined exp2 scale and tan index shift
    assign w_sh   = 5'(29 - TABLE_BITS) - {1'b0, r_off[14:11]};
    assign w_ti   = (r_pt[31:16] >= 16'(TSIZE)) ? TAB_ADDR_W'(TSIZE - 1)
                                               : TAB_ADDR_W'(r_pt[31:16]);

    assign w_av   = w_lerp + 36'sd16384;
    assign w_a21  = w_av[35:15];
    always_comb begin
        if (w_a21 > 21'sd32767) begin
            w_a = 16'sh7FFF;
        end else if (w_a21 < -21'sd32768) begin
            w_a = 16'sh8000;
        end else begin
            w_a = w_a21[15:0];
        end
    end

    assign w_fb_eff = (r_fb > FB_MAX) ? FB_MAX : r_fb;
    assign w_depth  = (r_depth > DEPTH_MAX) ? DEPTH_MAX : r_depth;
    assign w_nch    = (r_chan_cfg > 2'(CHANNELS)) ? 2'(CHANNELS) : r_chan_cfg;
    assign w_dry    = r_dry[r_ch[0]];
    assign w_ap_idx = AW'(int'(r_ch) * STAGES + int'(r_stage));
    assign w_r15    = rnd15(53'(r_prod));
    assign w_mix    = rnd15(53'(r_acc) + 53'(r_prod));

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_acc_in) n_state = S_SIN_RD0;
            S_SIN_RD0:   n_state = S_SIN_RD1;
            S_SIN_RD1:   n_state = S_SIN_MUL;
            S_SIN_MUL:   n_state = S_SIN_FIN;
            S_SIN_FIN:   n_state = S_LOG_MUL;
            S_LOG_MUL:   n_state = S_LOG_FIN;
            S_LOG_FIN:   n_state = S_EXP_RD0;
            S_EXP_RD0:   n_state = S_EXP_RD1;
            S_EXP_RD1:   n_state = S_EXP_MUL;
            S_EXP_MUL:   n_state = S_EXP_FIN;
            S_EXP_FIN:   n_state = S_TAN_RD0;
            S_TAN_RD0:   n_state = S_TAN_RD1;
            S_TAN_RD1:   n_state = S_TAN_MUL;
            S_TAN_MUL:   n_state = S_TAN_FIN;
            S_TAN_FIN:   n_state = (r_nch == 2'd0) ? S_DONE : S_FB_MUL;
            S_FB_MUL:    n_state = S_FB_FIN;
            S_FB_FIN:    n_state = S_AP_MUL_X;
            S_AP_MUL_X:  n_state = S_AP_Y;
            S_AP_Y:      n_state = S_AP_MUL_Y;
            S_AP_MUL_Y:  n_state = S_AP_Z;
            S_AP_Z:      n_state = (r_stage == SW'(STAGES - 1)) ? S_MIX_MUL_D : S_AP_MUL_X;
            S_MIX_MUL_D: n_state = S_MIX_MUL_W;
            S_MIX_MUL_W: n_state = S_MIX_FIN;
            S_MIX_FIN:   n_state = (r_ch + 2'd1 < r_nch) ? S_FB_MUL : S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs of the sequencer: multiplier operands, table reads, ready
    // ---------------------------------------------------------------------
    always_comb begin
        w_ma       = '0;
        w_mb       = '0;
        w_req.sel  = TAB_SIN;
        w_req.addr = TAB_ADDR_W'(w_si);
        w_in_ready = 1'b0;
        case (r_state)
            S_IDLE:      w_in_ready = !r_ovalid;
            S_SIN_RD0:   w_req.addr = TAB_ADDR_W'(w_si);
            S_SIN_RD1:   w_req.addr = TAB_ADDR_W'(w_si) + TAB_ADDR_W'(1);
            S_SIN_MUL: begin
                w_ma = 34'(w_tab) - 34'(r_ta);
                w_mb = $signed({2'b0, w_sf});
            end
            S_LOG_MUL: begin
                w_ma = 34'(w_diff);
                w_mb = $signed({1'b0, r_u});
            end
            S_EXP_RD0: begin
                w_req.sel  = TAB_EXP;
                w_req.addr = TAB_ADDR_W'(w_ei);
            end
            S_EXP_RD1: begin
                w_req.sel  = TAB_EXP;
                w_req.addr = TAB_ADDR_W'(w_ei) + TAB_ADDR_W'(1);
            end
            S_EXP_MUL: begin
                w_ma = 34'(w_tab) - 34'(r_ta);
                w_mb = $signed({2'b0, w_ef});
            end
            S_TAN_RD0: begin
                w_req.sel  = TAB_TAN;
                w_req.addr = w_ti;
            end
            S_TAN_RD1: begin
                w_req.sel  = TAB_TAN;
                w_req.addr = w_ti + TAB_ADDR_W'(1);
            end
            S_TAN_MUL: begin
                w_ma = 34'(w_tab) - 34'(r_ta);
                w_mb = $signed({2'b0, r_pt[15:0]});
            end
            S_FB_MUL: begin
                w_ma = 34'(r_fbm[r_ch[CIW-1:0]]);
                w_mb = $signed({3'b0, w_fb_eff});
            end
            S_AP_MUL_X: begin
                w_ma = 34'(r_x);
                w_mb = 18'(r_a);
            end
            S_AP_MUL_Y: begin
                w_ma = 34'(r_y);
                w_mb = 18'(r_a);
            end
            S_MIX_MUL_D: begin
                w_ma = 34'(w_dry);
                w_mb = $signed({2'b0, 16'(DEPTH_MAX - w_depth)});
            end
            S_MIX_MUL_W: begin
                w_ma = 34'(r_x);
                w_mb = $signed({2'b0, w_depth});
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // Shared multiplier, registered every cycle
        r_prod <= w_ma * w_mb;

        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_phase    <= '0;
            r_min      <= RST_MIN_LOG;
            r_max      <= RST_MAX_LOG;
            r_step     <= RST_LFO_STEP;
            r_fb       <= RST_FB_GAIN;
            r_depth    <= RST_DEPTH;
            r_chan_cfg <= RST_CHANNELS;
            r_ch       <= '0;
            r_stage    <= '0;
            r_nch      <= '0;
            for (int i = 0; i < NAP; i++) begin
                r_ap[i] <= '0;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                r_fbm[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_LOG:  r_min      <= i_cfg_data[15:0];
                    CFG_MAX_LOG:  r_max      <= i_cfg_data[15:0];
                    CFG_LFO_STEP: r_step     <= i_cfg_data[30:0];
                    CFG_FB_GAIN:  r_fb       <= i_cfg_data[14:0];
                    CFG_DEPTH:    r_depth    <= i_cfg_data[15:0];
                    CFG_CHANNELS: r_chan_cfg <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (w_acc_out) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        // Use the phase held before the advance
                        r_cur_ph <= r_phase;
                        r_phase  <= r_phase + {1'b0, r_step};
                        r_dry[0] <= i_in.left_in;
                        r_dry[1] <= i_in.right_in;
                        r_out[0] <= '0;
                        r_out[1] <= '0;
                        r_nch    <= w_nch;
                        r_ch     <= '0;
                        r_stage  <= '0;
                    end
                end
                S_SIN_RD1, S_EXP_RD1, S_TAN_RD1: r_ta <= w_tab;
                S_SIN_FIN:  r_u   <= w_u;
                S_LOG_FIN:  r_off <= w_offs[14:0];
                S_EXP_FIN:  r_pt  <= w_mant >> w_sh;
                S_TAN_FIN:  r_a   <= w_a;
                S_FB_FIN:   r_x   <= sat32(53'(w_dry) + 53'(w_r15));
                S_AP_Y:     r_y   <= sat32(53'(w_r15) + 53'(r_ap[w_ap_idx]));
                S_AP_Z: begin
                    r_ap[w_ap_idx] <= sat32(53'(r_x) - 53'(w_r15));
                    r_x            <= r_y;
                    r_stage        <= (r_stage == SW'(STAGES - 1)) ? '0 : r_stage + SW'(1);
                end
                S_MIX_MUL_W: r_acc <= r_prod;
                S_MIX_FIN: begin
                    r_fbm[r_ch[CIW-1:0]] <= r_x;
                    r_out[r_ch[0]]       <= sat24(w_mix);
                    r_ch                 <= r_ch + 2'd1;
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_out[0];
    assign o_out.right_out = r_out[1];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PHS_ASSERT_NOW(a_ready_only_idle, i_in.ready, r_state == S_IDLE, "ready outside idle")
    `PHS_ASSERT_NEXT(a_accept_starts, w_acc_in, r_state == S_SIN_RD0, "accepted frame not started")
    `PHS_ASSERT_NOW(a_no_take_while_held, r_ovalid, !i_in.ready, "frame taken while result held")
    `PHS_ASSERT_NOW(a_stage_range, 1'b1, r_stage <= SW'(STAGES - 1), "stage counter out of range")

endmodule

`default_nettype wire
